@@ design/crcdf_pkg.sv @@
// ----------------------------------------------------------------------------
// crcdf_pkg
// Shared types and codes of the CRC-16 packet deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package crcdf_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CrcW    = 16;
  localparam int unsigned StatusW = 3;

  localparam logic [CrcW-1:0] CrcPoly = 16'h1021;

  // Framing bytes
  localparam logic [ByteW-1:0] START_SHORT = 8'd2;
  localparam logic [ByteW-1:0] START_LONG  = 8'd3;
  localparam logic [ByteW-1:0] END_MARK    = 8'd3;

  // Result status codes
  localparam logic [StatusW-1:0] STAT_NONE      = 3'd0;
  localparam logic [StatusW-1:0] STAT_OK        = 3'd1;
  localparam logic [StatusW-1:0] STAT_CRC_ERR   = 3'd2;
  localparam logic [StatusW-1:0] STAT_BAD_END   = 3'd3;
  localparam logic [StatusW-1:0] STAT_LONG      = 3'd4;
  localparam logic [StatusW-1:0] STAT_BAD_START = 3'd5;

  typedef struct packed {
    logic [ByteW-1:0] rx_byte;
    logic             flush;
  } in_t;

  typedef struct packed {
    logic               payload_valid;
    logic [ByteW-1:0]   payload_byte;
    logic [ByteW-1:0]   payload_index;
    logic               frame_end;
    logic [StatusW-1:0] status;
    logic [ByteW-1:0]   frame_length;
  } out_t;

endpackage

`default_nettype wire

@@ design/crc16_packet_deframer.sv @@
// ----------------------------------------------------------------------------
// crc16_packet_deframer
// Byte-stream deframer with CRC-16/XMODEM check and per-byte results.
// ----------------------------------------------------------------------------
// Every accepted byte gives exactly one result, in order. One byte is taken
// per cycle while in_stall_o is low: a byte is registered at the input,
// decoded against the frame state in one pass (phase decode plus a one-byte
// CRC update), and the result registered at the output. A stalled output
// holds its result while one more byte can still sit in the input register;
// in_stall_o rises only when both are full.
`default_nettype none

module crc16_packet_deframer (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire crcdf_pkg::in_t  in_data_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output crcdf_pkg::out_t      out_data_o
);
  import crcdf_pkg::*;

  logic s1_valid_q;
  in_t  s1_data_q;
  logic out_valid_q;
  out_t out_data_q;
  out_t result;
  logic out_free;
  logic step;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign step       = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;

  crcdf_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .in_data_i (s1_data_q),
    .result_o  (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      s1_data_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // A status is reported exactly on frame ends
  a_status_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.frame_end == (out_data_o.status != STAT_NONE)))
    else $error("status and frame_end disagree");

  // Payload bytes never coincide with a frame end
  a_payload_not_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.payload_valid) |-> !out_data_o.frame_end)
    else $error("payload byte flagged as frame end");

  // Input stalls only with the input register occupied
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q))
    else $error("input stalled with free space");

  // A flushed byte yields an all-zero result
  a_flush_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && s1_data_q.flush) |=> (out_valid_o && (out_data_o == '0)))
    else $error("flush result not zero");

endmodule

`default_nettype wire

@@ design/crcdf_crc.sv @@
// ----------------------------------------------------------------------------
// crcdf_crc
// CRC-16/XMODEM update of a running CRC by one byte, MSB first.
// ----------------------------------------------------------------------------
`default_nettype none

module crcdf_crc (
  input  wire logic [crcdf_pkg::CrcW-1:0]  crc_i,
  input  wire logic [crcdf_pkg::ByteW-1:0] byte_i,
  output logic      [crcdf_pkg::CrcW-1:0]  crc_o
);
  import crcdf_pkg::*;

  always_comb begin
    logic [CrcW-1:0] c;
    c = crc_i ^ {byte_i, {(CrcW-ByteW){1'b0}}};
    for (int i = 0; i < ByteW; i++) begin
      if (c[CrcW-1]) begin
        c = {c[CrcW-2:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[CrcW-2:0], 1'b0};
      end
    end
    crc_o = c;
  end

endmodule

`default_nettype wire

@@ design/crcdf_core.sv @@
// ----------------------------------------------------------------------------
// crcdf_core
// Frame phase tracking, length and CRC state, and per-byte result decode.
// ----------------------------------------------------------------------------
`default_nettype none

module crcdf_core (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            step_i,
  input  wire crcdf_pkg::in_t  in_data_i,
  output crcdf_pkg::out_t      result_o
);
  import crcdf_pkg::*;

  localparam logic [2:0] PH_HUNT   = 3'd0;
  localparam logic [2:0] PH_LEN    = 3'd1;
  localparam logic [2:0] PH_DATA   = 3'd2;
  localparam logic [2:0] PH_CRC_HI = 3'd3;
  localparam logic [2:0] PH_CRC_LO = 3'd4;
  localparam logic [2:0] PH_END    = 3'd5;

  logic [2:0]       phase_q, phase_d;
  logic [ByteW-1:0] exp_len_q, exp_len_d;
  logic [ByteW-1:0] count_q, count_d;
  logic [CrcW-1:0]  run_crc_q, run_crc_d;
  logic [CrcW-1:0]  rx_crc_q, rx_crc_d;
  logic [CrcW-1:0]  crc_next;

  crcdf_crc u_crc (
    .crc_i  (run_crc_q),
    .byte_i (in_data_i.rx_byte),
    .crc_o  (crc_next)
  );

  always_comb begin
    phase_d   = phase_q;
    exp_len_d = exp_len_q;
    count_d   = count_q;
    run_crc_d = run_crc_q;
    rx_crc_d  = rx_crc_q;
    result_o  = '0;

    if (in_data_i.flush) begin
      phase_d = PH_HUNT;
    end else begin
      case (phase_q)
        PH_HUNT: begin
          if (in_data_i.rx_byte == START_SHORT) begin
            phase_d = PH_LEN;
          end else if (in_data_i.rx_byte == START_LONG) begin
            result_o.frame_end = 1'b1;
            result_o.status    = STAT_LONG;
          end else begin
            result_o.frame_end = 1'b1;
            result_o.status    = STAT_BAD_START;
          end
        end
        PH_LEN: begin
          exp_len_d = in_data_i.rx_byte;
          count_d   = '0;
          run_crc_d = '0;
          phase_d   = (in_data_i.rx_byte == '0) ? PH_CRC_HI : PH_DATA;
        end
        PH_DATA: begin
          result_o.payload_valid = 1'b1;
          result_o.payload_byte  = in_data_i.rx_byte;
          result_o.payload_index = count_q;
          run_crc_d = crc_next;
          count_d   = count_q + 1'b1;
          if (count_d == exp_len_q) begin
            phase_d = PH_CRC_HI;
          end
        end
        PH_CRC_HI: begin
          rx_crc_d = {in_data_i.rx_byte, {(CrcW-ByteW){1'b0}}};
          phase_d  = PH_CRC_LO;
        end
        PH_CRC_LO: begin
          rx_crc_d = {rx_crc_q[CrcW-1:ByteW], in_data_i.rx_byte};
          phase_d  = PH_END;
        end
        PH_END: begin
          result_o.frame_end    = 1'b1;
          result_o.frame_length = exp_len_q;
          if (in_data_i.rx_byte != END_MARK) begin
            result_o.status = STAT_BAD_END;
          end else if (rx_crc_q == run_crc_q) begin
            result_o.status = STAT_OK;
          end else begin
            result_o.status = STAT_CRC_ERR;
          end
          phase_d = PH_HUNT;
        end
        default: begin
          phase_d = PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HUNT;
      exp_len_q <= '0;
      count_q   <= '0;
      run_crc_q <= '0;
      rx_crc_q  <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      exp_len_q <= exp_len_d;
      count_q   <= count_d;
      run_crc_q <= run_crc_d;
      rx_crc_q  <= rx_crc_d;
    end
  end

endmodule

`default_nettype wire

@@ verif/crc16_packet_deframer_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc16_packet_deframer_tb
// Self-checking bench for the CRC-16/XMODEM packet deframer. Every accepted
// request is run through a local frame decoder and its expected result is
// queued; each result from the block is compared field by field with the
// oldest entry. The stimulus covers directed frame faults, output
// backpressure, random frames and noise, and a maximum-length frame.
// ----------------------------------------------------------------------------

module crc16_packet_deframer_tb;
  import crcdf_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned LongHold      = 150;

  typedef enum logic [2:0] {
    PH_HUNT, PH_LEN, PH_DATA, PH_CRC_HI, PH_CRC_LO, PH_END
  } deframe_phase_e;

  typedef enum int unsigned {
    FRAME_GOOD, FRAME_BAD_CRC, FRAME_BAD_END, FRAME_FLUSHED
  } frame_fault_e;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  out_t out_data_o;

  // decoder state, mirrors the block
  deframe_phase_e  dec_phase;
  logic [7:0]      dec_len;
  logic [7:0]      dec_count;
  logic [15:0]     dec_crc;
  logic [15:0]     dec_rx_crc;

  out_t        result_q[$];
  int unsigned err_cnt;
  int unsigned req_cnt;
  int unsigned res_cnt;
  int unsigned status_seen[8];
  int unsigned idle_cycles;
  bit          gap_en;
  bit          stall_en;
  bit          long_hold_req;

  crc16_packet_deframer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic logic [15:0] crc16_xmodem(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction

  // Advances the decoder by one request and returns what the block must report.
  function automatic out_t deframe_step(in_t req);
    out_t r;
    r = '0;
    r.status = STAT_NONE;
    if (req.flush) begin
      dec_phase = PH_HUNT;
    end else begin
      case (dec_phase)
        PH_HUNT: begin
          if (req.rx_byte == START_SHORT) begin
            dec_phase = PH_LEN;
          end else if (req.rx_byte == START_LONG) begin
            r.frame_end = 1'b1;
            r.status    = STAT_LONG;
          end else begin
            r.frame_end = 1'b1;
            r.status    = STAT_BAD_START;
          end
        end
        PH_LEN: begin
          dec_len   = req.rx_byte;
          dec_count = '0;
          dec_crc   = '0;
          dec_phase = (req.rx_byte == '0) ? PH_CRC_HI : PH_DATA;
        end
        PH_DATA: begin
          r.payload_valid = 1'b1;
          r.payload_byte  = req.rx_byte;
          r.payload_index = dec_count;
          dec_crc   = crc16_xmodem(dec_crc, req.rx_byte);
          dec_count = dec_count + 8'd1;
          if (dec_count == dec_len) dec_phase = PH_CRC_HI;
        end
        PH_CRC_HI: begin
          dec_rx_crc = {req.rx_byte, 8'h00};
          dec_phase  = PH_CRC_LO;
        end
        PH_CRC_LO: begin
          dec_rx_crc = {dec_rx_crc[15:8], req.rx_byte};
          dec_phase  = PH_END;
        end
        PH_END: begin
          r.frame_end    = 1'b1;
          r.frame_length = dec_len;
          if (req.rx_byte != END_MARK) r.status = STAT_BAD_END;
          else if (dec_rx_crc == dec_crc) r.status = STAT_OK;
          else r.status = STAT_CRC_ERR;
          dec_phase = PH_HUNT;
        end
        default: dec_phase = PH_HUNT;
      endcase
    end
    return r;
  endfunction

  // Offers one request, holds it until accepted, then maybe idles.
  task automatic send_req(in_t req);
    int unsigned gap;
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (in_stall_o);
    result_q.push_back(deframe_step(req));
    req_cnt++;
    if (gap_en && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 15);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_byte(logic [7:0] b);
    in_t req;
    req.rx_byte = b;
    req.flush   = 1'b0;
    send_req(req);
  endtask

  task automatic send_flush();
    in_t req;
    req.rx_byte = 8'($urandom);
    req.flush   = 1'b1;
    send_req(req);
  endtask

  task automatic wait_drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (result_q.size() != 0);
  endtask

  task automatic send_frame(int unsigned len, frame_fault_e fault);
    logic [7:0]  frame_q[$];
    logic [15:0] crc;
    logic [7:0]  b;
    int unsigned cut;
    crc = '0;
    frame_q.push_back(START_SHORT);
    frame_q.push_back(len[7:0]);
    for (int unsigned i = 0; i < len; i++) begin
      b = 8'($urandom);
      frame_q.push_back(b);
      crc = crc16_xmodem(crc, b);
    end
    if (fault == FRAME_BAD_CRC) crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
    frame_q.push_back(crc[15:8]);
    frame_q.push_back(crc[7:0]);
    if (fault == FRAME_BAD_END) begin
      do b = 8'($urandom); while (b == END_MARK);
      frame_q.push_back(b);
    end else begin
      frame_q.push_back(END_MARK);
    end
    cut = (fault == FRAME_FLUSHED) ? $urandom_range(1, frame_q.size() - 1) : frame_q.size();
    for (int unsigned i = 0; i < frame_q.size(); i++) begin
      if (i == cut) begin
        send_flush();
        break;
      end
      send_byte(frame_q[i]);
    end
  endtask

  function automatic int unsigned pick_len();
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (roll < 14) return $urandom_range(0, 8);
    if (roll < 19) return $urandom_range(9, 40);
    return $urandom_range(200, 255);
  endfunction

  task automatic test_directed();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(START_LONG);
    send_flush();
    send_frame(0, FRAME_GOOD);
    send_frame(1, FRAME_GOOD);
    send_frame(0, FRAME_BAD_CRC);
    send_frame(0, FRAME_BAD_END);
    send_byte(START_SHORT);
    send_flush();
  endtask

  // Output held off long enough that both pipeline slots fill and the input stalls.
  task automatic test_backpressure();
    gap_en = 1'b0;
    long_hold_req = 1'b1;
    send_frame(6, FRAME_GOOD);
    send_frame(0, FRAME_BAD_CRC);
    wait_drain();
    gap_en = 1'b1;
  endtask

  task automatic test_random_frames();
    int unsigned roll;
    while (req_cnt < 280) begin
      roll = $urandom_range(0, 19);
      if (roll < 11) send_frame(pick_len(), FRAME_GOOD);
      else if (roll < 13) send_frame(pick_len() % 16, FRAME_BAD_CRC);
      else if (roll < 15) send_frame(pick_len() % 16, FRAME_BAD_END);
      else if (roll < 17) send_frame(pick_len() % 16, FRAME_FLUSHED);
      else if (roll < 19) begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
        send_flush();
      end else begin
        wait_drain();
      end
    end
  endtask

  task automatic test_longest_frame();
    send_frame(255, FRAME_GOOD);
  endtask

  task automatic test_unthrottled();
    gap_en   = 1'b0;
    stall_en = 1'b0;
    send_frame(4, FRAME_GOOD);
    send_frame(3, FRAME_BAD_END);
    send_frame(8, FRAME_FLUSHED);
    send_byte(START_LONG);
    repeat (3) send_frame($urandom_range(0, 10), FRAME_GOOD);
    send_frame(2, FRAME_BAD_CRC);
  endtask

  // Receiver side: random stall bursts, plus one long hold on request.
  initial begin : out_stall_gen
    int unsigned n;
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        out_stall_i <= 1'b1;
        repeat (LongHold) @(posedge clk_i);
        out_stall_i   <= 1'b0;
        long_hold_req = 1'b0;
      end else if (stall_en && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 15);
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic report_field(string name, int unsigned e, int unsigned a);
    $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, e, a);
    err_cnt++;
  endtask

  always @(posedge clk_i) begin : result_check
    out_t exp_r;
    out_t act_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      act_r = out_data_o;
      res_cnt++;
      status_seen[act_r.status]++;
      if (result_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got 0x%0h", $time, act_r);
        err_cnt++;
      end else begin
        exp_r = result_q.pop_front();
        if (act_r.payload_valid !== exp_r.payload_valid)
          report_field("payload_valid", exp_r.payload_valid, act_r.payload_valid);
        if (act_r.payload_byte !== exp_r.payload_byte)
          report_field("payload_byte", exp_r.payload_byte, act_r.payload_byte);
        if (act_r.payload_index !== exp_r.payload_index)
          report_field("payload_index", exp_r.payload_index, act_r.payload_index);
        if (act_r.frame_end !== exp_r.frame_end)
          report_field("frame_end", exp_r.frame_end, act_r.frame_end);
        if (act_r.status !== exp_r.status)
          report_field("status", exp_r.status, act_r.status);
        if (act_r.frame_length !== exp_r.frame_length)
          report_field("frame_length", exp_r.frame_length, act_r.frame_length);
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("%0t: timeout, no request or result moved for %0d cycles, %0d pending",
                 $time, idle_cycles, result_q.size());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin : main_seq
    err_cnt       = 0;
    req_cnt       = 0;
    res_cnt       = 0;
    idle_cycles   = 0;
    gap_en        = 1'b1;
    stall_en      = 1'b1;
    long_hold_req = 1'b0;
    dec_phase     = PH_HUNT;
    dec_len       = '0;
    dec_count     = '0;
    dec_crc       = '0;
    dec_rx_crc    = '0;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i  <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_backpressure();
    test_random_frames();
    test_longest_frame();
    test_unthrottled();

    wait_drain();
    repeat (8) @(posedge clk_i);
    $display("Covered %0d requests and %0d results: ok %0d, crc err %0d, bad end %0d,",
             req_cnt, res_cnt, status_seen[STAT_OK], status_seen[STAT_CRC_ERR],
             status_seen[STAT_BAD_END]);
    $display("  long start %0d, bad start %0d, with output backpressure and flushes",
             status_seen[STAT_LONG], status_seen[STAT_BAD_START]);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
